>>> hw/rtl/pd2a_pkg.sv
// Shared types and character constants for the packed-decimal to ASCII block.
// No dependencies; imported by packed_decimal_to_ascii and its checker.
`timescale 1ns / 1ps

package pd2a_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_PRECISION = 2'd0;
  localparam logic [1:0] REG_SCALE     = 2'd1;

  // Reset values of the configuration registers
  localparam logic [4:0] PRECISION_RESET = 5'd5;
  localparam logic [4:0] SCALE_RESET     = 5'd0;

  // Character codes
  localparam logic [6:0] CHAR_DIGIT_BASE = 7'h30;
  localparam logic [6:0] CHAR_POINT      = 7'h2E;
  localparam logic [6:0] CHAR_PLUS       = 7'h2B;
  localparam logic [6:0] CHAR_MINUS      = 7'h2D;

  // Sign nibbles that read as positive
  localparam logic [3:0] SIGN_POS_A = 4'hA;
  localparam logic [3:0] SIGN_POS_C = 4'hC;
  localparam logic [3:0] SIGN_POS_E = 4'hE;
  localparam logic [3:0] SIGN_POS_F = 4'hF;

  // Position of the sign in the output string; digits start one above it
  localparam logic [5:0] SIGN_POSITION  = 6'd0;
  localparam logic [5:0] FIRST_POSITION = 6'd1;

  typedef struct packed {
    logic [6:0] code;
    logic [5:0] position;
    logic       done;
  } char_t;

endpackage

>>> hw/rtl/packed_decimal_to_ascii.sv
// Packed-decimal to ASCII converter, top level.
// Depends on pd2a_pkg for character codes, register indexes and char_t.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready/packed_byte): one byte of a packed
//   number per transfer, digit_precision/2+1 bytes per number, high nibble
//   first, the sign in the final low nibble.
//   Output channel (out_valid/out_ready/char_code/char_position/
//   number_done): one character per transfer. Digits and the point carry
//   their string position from 1 upward; the sign goes out last at
//   position 0 with number_done high.
//   Configuration (cfg_write/cfg_index/cfg_data): index 0 is the precision,
//   index 1 the scale; other indexes are dropped. A write restarts the
//   number. Write only while the block is idle.
// Timing
//   A byte waits in the input register until the result buffer is free,
//   then its characters are loaded into the result buffer, from which the
//   first character is offered. A byte gives one to three characters
//   and the result channel moves one per cycle while out_ready is high.
//   The next byte is taken while the last character of the current one
//   is still waiting.
// Reset and stalls
//   rst empties both registers and returns to the start of a number with
//   precision 5 and scale 0. A stalled receiver holds the buffer; the input
//   register then fills and in_ready drops until the buffer drains.
module packed_decimal_to_ascii #(
  parameter int MAX_PRECISION = 31
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] packed_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] char_code,
  output logic [5:0] char_position,
  output logic       number_done,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data
);
  import pd2a_pkg::*;

  // Outcome of handling one digit nibble
  typedef struct packed {
    logic [5:0]        nc;
    logic [5:0]        wp;
    logic signed [6:0] pt;
    logic              emit_digit;
    logic [5:0]        digit_pos;
    logic              emit_point;
    logic [5:0]        point_pos;
  } nib_step_t;

  function automatic nib_step_t nib_step(input logic [3:0]        nib,
                                         input logic [5:0]        nc,
                                         input logic [5:0]        wp,
                                         input logic signed [6:0] pt,
                                         input logic              even);
    nib_step_t r;
    r.nc         = nc + 6'd1;
    r.wp         = wp;
    r.pt         = pt;
    r.digit_pos  = wp;
    // A leading zero pad nibble is swallowed and moves the point one on
    r.emit_digit = !((r.nc == 6'd1) && even && (nib == 4'd0));
    if (r.emit_digit) begin
      r.wp = wp + 6'd1;
    end else begin
      r.pt = pt + 7'sd1;
    end
    r.emit_point = ($signed({1'b0, r.nc}) == r.pt);
    r.point_pos  = r.wp;
    if (r.emit_point) begin
      r.wp = r.wp + 6'd1;
    end
    return r;
  endfunction

  // Configuration registers
  logic [4:0] digit_precision;
  logic [4:0] digit_scale;

  // Number state
  logic [5:0]        nibble_count;
  logic [5:0]        write_position;
  logic signed [6:0] point_target;
  logic [4:0]        byte_count;

  // Input register
  logic       in_full;
  logic [7:0] in_byte;

  // Result buffer: four slots, sent lowest first
  logic [3:0] buf_valid;
  char_t      buf_char [4];

  logic       buf_free;
  logic       move;
  logic       out_take;
  logic [1:0] sel;

  logic [4:0]        prec;
  logic              last_byte;
  logic [3:0]        hi_nib;
  logic [3:0]        lo_nib;
  logic [5:0]        nc_start;
  logic [5:0]        wp_start;
  logic signed [6:0] pt_start;
  nib_step_t         hi_res;
  nib_step_t         lo_res;
  logic              sign_pos;
  logic [3:0]        load_valid;
  char_t             load_char [4];

  // Handshakes
  assign out_valid = |buf_valid;
  assign out_take  = out_valid && out_ready;
  assign buf_free  = (buf_valid == 4'd0) || ($onehot(buf_valid) && out_ready);
  assign move      = in_full && buf_free;
  assign in_ready  = !in_full || move;

  // Precision above the build limit saturates
  assign prec = (int'(digit_precision) > MAX_PRECISION) ? 5'(MAX_PRECISION)
                                                       : digit_precision;
  assign last_byte = (byte_count >= {1'b0, prec[4:1]});
  assign hi_nib    = in_byte[7:4];
  assign lo_nib    = in_byte[3:0];

  // First byte of a number reloads the counters and the point target
  always_comb begin
    if (byte_count == 5'd0) begin
      nc_start = 6'd0;
      wp_start = FIRST_POSITION;
      pt_start = $signed({2'b00, prec}) - $signed({2'b00, digit_scale});
    end else begin
      nc_start = nibble_count;
      wp_start = write_position;
      pt_start = point_target;
    end
  end

  assign hi_res = nib_step(hi_nib, nc_start, wp_start, pt_start, !prec[0]);
  assign lo_res = nib_step(lo_nib, hi_res.nc, hi_res.wp, hi_res.pt, !prec[0]);

  assign sign_pos = (lo_nib == SIGN_POS_A) || (lo_nib == SIGN_POS_C) ||
                    (lo_nib == SIGN_POS_E) || (lo_nib == SIGN_POS_F);

  // Characters caused by the byte in the input register
  always_comb begin
    load_valid[0] = hi_res.emit_digit;
    load_char[0]  = '{code: CHAR_DIGIT_BASE | {3'b000, hi_nib},
                      position: hi_res.digit_pos, done: 1'b0};
    load_valid[1] = hi_res.emit_point;
    load_char[1]  = '{code: CHAR_POINT, position: hi_res.point_pos, done: 1'b0};
    if (last_byte) begin
      load_valid[2] = 1'b1;
      load_char[2]  = '{code: sign_pos ? CHAR_PLUS : CHAR_MINUS,
                        position: SIGN_POSITION, done: 1'b1};
      load_valid[3] = 1'b0;
    end else begin
      load_valid[2] = lo_res.emit_digit;
      load_char[2]  = '{code: CHAR_DIGIT_BASE | {3'b000, lo_nib},
                        position: lo_res.digit_pos, done: 1'b0};
      load_valid[3] = lo_res.emit_point;
    end
    load_char[3] = '{code: CHAR_POINT, position: lo_res.point_pos, done: 1'b0};
  end

  // Configuration and number state
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_precision <= PRECISION_RESET;
      digit_scale     <= SCALE_RESET;
      nibble_count    <= 6'd0;
      write_position  <= FIRST_POSITION;
      point_target    <= 7'sd0;
      byte_count      <= 5'd0;
    end else if (cfg_write && (cfg_index == REG_PRECISION || cfg_index == REG_SCALE)) begin
      if (cfg_index == REG_PRECISION) begin
        digit_precision <= cfg_data;
      end else begin
        digit_scale <= cfg_data;
      end
      // Abandon the number in progress
      nibble_count   <= 6'd0;
      write_position <= FIRST_POSITION;
      point_target   <= 7'sd0;
      byte_count     <= 5'd0;
    end else if (move) begin
      if (last_byte) begin
        nibble_count   <= 6'd0;
        write_position <= FIRST_POSITION;
        point_target   <= 7'sd0;
        byte_count     <= 5'd0;
      end else begin
        nibble_count   <= lo_res.nc;
        write_position <= lo_res.wp;
        point_target   <= lo_res.pt;
        byte_count     <= byte_count + 5'd1;
      end
    end
  end

  // Input register: hold the byte until the buffer can take its characters
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= packed_byte;
    end
  end

  // Lowest pending slot goes out first
  always_comb begin
    if (buf_valid[0]) begin
      sel = 2'd0;
    end else if (buf_valid[1]) begin
      sel = 2'd1;
    end else if (buf_valid[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 4'd0;
    end else if (move) begin
      buf_valid <= load_valid;
    end else if (out_take) begin
      buf_valid[sel] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      for (int k = 0; k < 4; k++) begin
        buf_char[k] <= load_char[k];
      end
    end
  end

  assign char_code     = buf_char[sel].code;
  assign char_position = buf_char[sel].position;
  assign number_done   = buf_char[sel].done;

endmodule

>>> hw/rtl/pd2a_checker.sv
// Port-level checker for packed_decimal_to_ascii, bound to the top level.
// Depends on pd2a_pkg for character codes and the sign position.
`timescale 1ns / 1ps

module pd2a_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] char_code,
  input logic [5:0] char_position,
  input logic       number_done
);
  import pd2a_pkg::*;

  // Reset empties the result buffer
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered straight after reset");

  // A stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_code) &&
                                $stable(char_position) && $stable(number_done))
    else $error("stalled character changed");

  // The sign sits at position 0 and carries a sign code
  a_sign_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && number_done |->
      char_position == SIGN_POSITION && (char_code == CHAR_PLUS || char_code == CHAR_MINUS))
    else $error("bad sign character");

  // Digits and points never land on the sign position
  a_body_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && !number_done |->
      char_position != SIGN_POSITION &&
      (char_code == CHAR_POINT || char_code[6:4] == CHAR_DIGIT_BASE[6:4]))
    else $error("bad digit or point character");

endmodule

bind packed_decimal_to_ascii pd2a_checker u_pd2a_checker (.*);
